FILE: rtl/soc_pkg.sv
// Shared types, opcode constants and opcode class tables for the script opcode checker.
// No dependencies; imported by the parser, the result register and the core.
`default_nettype none

package soc_pkg;

  localparam int unsigned CounterBitsDef   = 16;
  localparam int unsigned SizeBits         = 16;
  localparam logic [15:0] MaxSizeReset     = 16'd10000;

  localparam logic [7:0] OP_0              = 8'h00;
  localparam logic [7:0] OP_PUSHBYTES_1    = 8'h01;
  localparam logic [7:0] OP_PUSHBYTES_75   = 8'h4B;
  localparam logic [7:0] OP_PUSH_LEN1      = 8'h4C;
  localparam logic [7:0] OP_PUSH_LEN4      = 8'h4E;
  localparam logic [7:0] OP_1NEGATE        = 8'h4F;
  localparam logic [7:0] OP_IF             = 8'h63;
  localparam logic [7:0] OP_IF_NOT         = 8'h64;
  localparam logic [7:0] OP_IF_END         = 8'h68;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TOO_LARGE   = 4'd1,
    ST_SHORT_PUSH  = 4'd2,
    ST_PD1_LEN     = 4'd3,
    ST_PD1_DATA    = 4'd4,
    ST_PD2_LEN     = 4'd5,
    ST_PD2_DATA    = 4'd6,
    ST_PD4_LEN     = 4'd7,
    ST_PD4_DATA    = 4'd8,
    ST_STRAY_ENDIF = 4'd9,
    ST_DISABLED    = 4'd10,
    ST_UNKNOWN     = 4'd11,
    ST_OPEN_IF     = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    MODE_OPCODE = 2'd0,
    MODE_LEN    = 2'd1,
    MODE_DATA   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PUSH_DIRECT = 2'd0,
    PUSH_PD1    = 2'd1,
    PUSH_PD2    = 2'd2,
    PUSH_PD4    = 2'd3
  } push_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
    logic [7:0]  opcode;
    logic [15:0] depth;
  } verdict_t;

  function automatic logic is_disabled(input logic [7:0] op);
    is_disabled = (op >= 8'h7D && op <= 8'h81) || (op >= 8'h89 && op <= 8'h8B) ||
                  (op >= 8'h93 && op <= 8'h99);
  endfunction

  function automatic logic is_known(input logic [7:0] op);
    case (op)
      8'h00, 8'h51, 8'h52, 8'h63, 8'h64, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h75,
      8'h76, 8'h7C, 8'h82, 8'h87, 8'h88, 8'hA9, 8'hAC, 8'hAE, 8'hB1,
      8'hB2: is_known = 1'b1;
      default: is_known = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/soc_in_stage.sv
// Input register of the script opcode checker: holds one accepted script byte.
// Depends on nothing but the clock and reset.
`default_nettype none

module soc_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] s_byte_i,
  input  wire logic       s_last_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
      last_q <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/soc_parser.sv
// Per-script parse state and verdict logic of the script opcode checker.
// Depends on soc_pkg for opcode constants, status codes and class tables.
`default_nettype none

module soc_parser #(
  parameter int unsigned CounterBits = soc_pkg::CounterBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             fire_i,
  input  wire logic [7:0]                       byte_i,
  input  wire logic                             last_i,
  input  wire logic [soc_pkg::SizeBits-1:0]     max_size_i,
  output soc_pkg::verdict_t                     verdict_o
);
  import soc_pkg::*;

  localparam int unsigned CmpW = (CounterBits > SizeBits) ? CounterBits : SizeBits;

  mode_e                  mode_q, mode_d, mode_n;
  logic [2:0]             len_left_q, len_left_d, len_left_n;
  logic [31:0]            accum_q, accum_d, accum_n;
  logic [31:0]            data_left_q, data_left_d, data_left_n;
  logic [CounterBits-1:0] byte_cnt_q, byte_cnt_d, byte_cnt_n;
  logic [CounterBits-1:0] push_off_q, push_off_d, push_off_n;
  push_e                  push_kind_q, push_kind_d, push_kind_n;
  logic [CounterBits-1:0] if_depth_q, if_depth_d, if_depth_n;
  status_e                first_err_q, first_err_d, first_err_n;
  logic [CounterBits-1:0] fault_off_q, fault_off_d, fault_off_n;
  logic [7:0]             fault_op_q, fault_op_d, fault_op_n;

  logic [2:0]             len_total;
  logic [1:0]             lane;
  logic [CmpW-1:0]        cnt_ext, max_ext, depth_ext, push_off_ext, fault_off_ext, off_ext;
  logic [7:0]             kind_op;

  // Walk one byte through the parse state.
  always_comb begin
    mode_n      = mode_q;
    len_left_n  = len_left_q;
    accum_n     = accum_q;
    data_left_n = data_left_q;
    push_off_n  = push_off_q;
    push_kind_n = push_kind_q;
    if_depth_n  = if_depth_q;
    first_err_n = first_err_q;
    fault_off_n = fault_off_q;
    fault_op_n  = fault_op_q;
    byte_cnt_n  = (byte_cnt_q == '1) ? byte_cnt_q : byte_cnt_q + 1'b1;
    len_total   = (push_kind_q == PUSH_PD4) ? 3'd4 : {1'b0, push_kind_q};
    lane        = 2'(len_total - len_left_q);

    if (first_err_q == ST_OK) begin
      if (mode_q == MODE_LEN && len_left_q != '0 && push_kind_q != PUSH_DIRECT) begin
        accum_n[{lane, 3'b000} +: 8] = byte_i;
        len_left_n = len_left_q - 1'b1;
        if (len_left_n == '0) begin
          data_left_n = accum_n;
          mode_n      = (accum_n != '0) ? MODE_DATA : MODE_OPCODE;
        end
      end else if (mode_q == MODE_DATA && data_left_q != '0) begin
        data_left_n = data_left_q - 1'b1;
        if (data_left_n == '0) begin
          mode_n = MODE_OPCODE;
        end
      end else begin
        mode_n = MODE_OPCODE;
        if (byte_i >= OP_PUSHBYTES_1 && byte_i <= OP_PUSHBYTES_75) begin
          push_kind_n = PUSH_DIRECT;
          push_off_n  = byte_cnt_q;
          accum_n     = {24'd0, byte_i};
          data_left_n = {24'd0, byte_i};
          mode_n      = MODE_DATA;
        end else if (byte_i >= OP_PUSH_LEN1 && byte_i <= OP_PUSH_LEN4) begin
          push_kind_n = push_e'(2'(byte_i - OP_PUSHBYTES_75));
          push_off_n  = byte_cnt_q;
          accum_n     = '0;
          len_left_n  = (push_kind_n == PUSH_PD4) ? 3'd4 : {1'b0, push_kind_n};
          mode_n      = MODE_LEN;
        end else if (byte_i == OP_IF_END && if_depth_q == '0) begin
          first_err_n = ST_STRAY_ENDIF;
          fault_off_n = byte_cnt_q;
          fault_op_n  = byte_i;
        end else begin
          if (byte_i == OP_IF || byte_i == OP_IF_NOT) begin
            if_depth_n = (if_depth_q == '1) ? if_depth_q : if_depth_q + 1'b1;
          end else if (byte_i == OP_IF_END) begin
            if_depth_n = if_depth_q - 1'b1;
          end
          if (is_disabled(byte_i)) begin
            first_err_n = ST_DISABLED;
            fault_off_n = byte_cnt_q;
            fault_op_n  = byte_i;
          end else if (byte_i >= OP_1NEGATE && !is_known(byte_i)) begin
            first_err_n = ST_UNKNOWN;
            fault_off_n = byte_cnt_q;
            fault_op_n  = byte_i;
          end
        end
      end
    end
  end

  assign cnt_ext       = CmpW'(byte_cnt_n);
  assign max_ext       = CmpW'(max_size_i);
  assign depth_ext     = CmpW'(if_depth_n);
  assign push_off_ext  = CmpW'(push_off_n);
  assign fault_off_ext = CmpW'(fault_off_n);
  assign kind_op       = OP_PUSHBYTES_75 + {6'd0, push_kind_n};

  // Rank the faults: size first, then the frozen fault, then an open push, then open IF.
  always_comb begin
    verdict_o.status = ST_OK;
    verdict_o.opcode = '0;
    verdict_o.depth  = depth_ext[15:0];
    off_ext          = '0;
    if (cnt_ext > max_ext) begin
      verdict_o.status = ST_TOO_LARGE;
    end else if (first_err_n != ST_OK) begin
      verdict_o.status = first_err_n;
      off_ext          = fault_off_ext;
      verdict_o.opcode = fault_op_n;
    end else if (mode_n == MODE_LEN) begin
      off_ext          = push_off_ext;
      verdict_o.opcode = kind_op;
      case (push_kind_n)
        PUSH_PD1: verdict_o.status = ST_PD1_LEN;
        PUSH_PD2: verdict_o.status = ST_PD2_LEN;
        PUSH_PD4: verdict_o.status = ST_PD4_LEN;
        default:  verdict_o.status = ST_SHORT_PUSH;
      endcase
    end else if (mode_n == MODE_DATA) begin
      off_ext          = push_off_ext;
      verdict_o.opcode = kind_op;
      case (push_kind_n)
        PUSH_PD1: verdict_o.status = ST_PD1_DATA;
        PUSH_PD2: verdict_o.status = ST_PD2_DATA;
        PUSH_PD4: verdict_o.status = ST_PD4_DATA;
        default: begin
          verdict_o.status = ST_SHORT_PUSH;
          verdict_o.opcode = accum_n[7:0];
        end
      endcase
    end else if (if_depth_n != '0) begin
      verdict_o.status = ST_OPEN_IF;
    end
    verdict_o.offset = off_ext[15:0];
  end

  // Clear all per-script state when the last byte of a script is taken.
  always_comb begin
    if (last_i) begin
      mode_d      = MODE_OPCODE;
      len_left_d  = '0;
      accum_d     = '0;
      data_left_d = '0;
      byte_cnt_d  = '0;
      push_off_d  = '0;
      push_kind_d = PUSH_DIRECT;
      if_depth_d  = '0;
      first_err_d = ST_OK;
      fault_off_d = '0;
      fault_op_d  = '0;
    end else begin
      mode_d      = mode_n;
      len_left_d  = len_left_n;
      accum_d     = accum_n;
      data_left_d = data_left_n;
      byte_cnt_d  = byte_cnt_n;
      push_off_d  = push_off_n;
      push_kind_d = push_kind_n;
      if_depth_d  = if_depth_n;
      first_err_d = first_err_n;
      fault_off_d = fault_off_n;
      fault_op_d  = fault_op_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OPCODE;
      len_left_q  <= '0;
      accum_q     <= '0;
      data_left_q <= '0;
      byte_cnt_q  <= '0;
      push_off_q  <= '0;
      push_kind_q <= PUSH_DIRECT;
      if_depth_q  <= '0;
      first_err_q <= ST_OK;
      fault_off_q <= '0;
      fault_op_q  <= '0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      len_left_q  <= len_left_d;
      accum_q     <= accum_d;
      data_left_q <= data_left_d;
      byte_cnt_q  <= byte_cnt_d;
      push_off_q  <= push_off_d;
      push_kind_q <= push_kind_d;
      if_depth_q  <= if_depth_d;
      first_err_q <= first_err_d;
      fault_off_q <= fault_off_d;
      fault_op_q  <= fault_op_d;
    end
  end

`ifndef ASSERT_OFF
  a_data_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_DATA |-> data_left_q != '0)
    else $error("data mode with no data bytes left");

  a_len_mode_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_LEN |-> push_kind_q != PUSH_DIRECT && len_left_q != '0 &&
                           len_left_q <= 3'd4)
    else $error("length mode with bad push kind or count");

  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> byte_cnt_q == '0 && first_err_q == ST_OK && if_depth_q == '0)
    else $error("script state not cleared after verdict");

  a_fault_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_err_q != ST_OK && !(fire_i && last_i) |=>
      $stable(if_depth_q) && $stable(mode_q) && $stable(first_err_q))
    else $error("parse state moved after first fault");
`endif

endmodule

`default_nettype wire

FILE: rtl/soc_out_stage.sv
// Result register of the script opcode checker: holds one verdict until taken.
// Depends on soc_pkg for the verdict type.
`default_nettype none

module soc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire soc_pkg::verdict_t verdict_i,
  output logic                   can_load_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output logic [47:0]            m_data_o
);
  import soc_pkg::*;

  logic     valid_q, valid_d;
  verdict_t res_q;

  assign can_load_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= verdict_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {4'd0, res_q.depth, res_q.opcode, res_q.offset, res_q.status};

endmodule

`default_nettype wire

FILE: rtl/script_opcode_checker_core.sv
// Path: an accepted script byte is held in the input register and parsed from there; the
// verdict of the last byte is registered in the result register, and a full one stalls it.
// Throughput: one byte per cycle while bytes are fed; a waiting verdict only
// stalls a further last byte, never the bytes of the following script.
// Reset (rst_ni low, asynchronous): pipeline empty, parse state cleared, max size 10000.
`default_nettype none

module script_opcode_checker_core #(
  parameter int unsigned CounterBits = soc_pkg::CounterBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // script bytes in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] script_byte
  input  wire logic                          s_axis_tlast,   // last_byte
  // verdicts out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [47:0]                        m_axis_tdata,   // [3:0] status,
                                                             // [19:4] error_offset,
                                                             // [27:20] error_opcode,
                                                             // [43:28] open_if_depth,
                                                             // [47:44] zero
  // script size limit register
  input  wire logic                          cfg_we_i,
  input  wire logic [soc_pkg::SizeBits-1:0]  cfg_wdata_i
);
  import soc_pkg::*;

  logic [SizeBits-1:0] max_size_q;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                out_can_load;
  logic                fire;
  logic                load_result;
  verdict_t            verdict;

  // Write configuration only while idle (not enforced); loaded whenever enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxSizeReset;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  // Advance the held word through the parser unless it is a last byte and the
  // result register is still full.
  assign fire        = in_valid && (!in_last || out_can_load);
  assign load_result = fire && in_last;

  soc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .take_i    (fire),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .last_o    (in_last)
  );

  // Parse state walks one byte per fire; verdict is combinational from the new state.
  soc_parser #(
    .CounterBits (CounterBits)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte),
    .last_i     (in_last),
    .max_size_i (max_size_q),
    .verdict_o  (verdict)
  );

  // Hold the verdict until the sink takes it.
  soc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load_result),
    .verdict_i  (verdict),
    .can_load_o (out_can_load),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !load_result)
    else $error("verdict overwritten while stalled");

  a_bytes_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_last |-> s_axis_tready)
    else $error("input stalled behind a non-last word");

  a_verdict_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> m_axis_tvalid)
    else $error("loaded verdict not presented");
`endif

endmodule

`default_nettype wire
